@@ hdl/utc_time_string_parser_defines.svh @@
// assertion macros shared by the time string parser modules
// no dependencies
`ifndef UTC_TIME_STRING_PARSER_DEFINES_SVH
`define UTC_TIME_STRING_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UTSP_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UTSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/utsp_pkg.sv @@
// types, codes and constants of the time string parser
// no dependencies
`default_nettype none

package utsp_pkg;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TAG   = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_ZONE  = 3'd4;
  localparam logic [2:0] ST_LEN   = 3'd5;

  // byte position codes
  localparam logic [4:0] PH_START      = 5'd0;
  localparam logic [4:0] PH_YEAR4      = 5'd3;
  localparam logic [4:0] PH_MONTH1     = 5'd4;
  localparam logic [4:0] PH_MONTH2     = 5'd5;
  localparam logic [4:0] PH_DAY1       = 5'd6;
  localparam logic [4:0] PH_DAY2       = 5'd7;
  localparam logic [4:0] PH_HOUR1      = 5'd8;
  localparam logic [4:0] PH_HOUR2      = 5'd9;
  localparam logic [4:0] PH_AFTER_HOUR = 5'd10;
  localparam logic [4:0] PH_MIN2       = 5'd11;
  localparam logic [4:0] PH_ZONE       = 5'd12;
  localparam logic [4:0] PH_ZH1        = 5'd13;
  localparam logic [4:0] PH_ZH2        = 5'd14;
  localparam logic [4:0] PH_ZM1        = 5'd15;
  localparam logic [4:0] PH_ZM2        = 5'd16;
  localparam logic [4:0] PH_DONE       = 5'd17;

  // characters
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // range limits
  localparam logic [13:0] YEAR_MIN  = 14'd1900;
  localparam logic [6:0]  MONTH_MAX = 7'd12;
  localparam logic [6:0]  DAY_MAX   = 7'd31;
  localparam logic [6:0]  HOUR_MAX  = 7'd23;
  localparam logic [6:0]  MIN_MAX   = 7'd59;
  localparam logic [17:0] SEC_PER_MIN  = 18'd60;
  localparam logic [17:0] SEC_PER_HOUR = 18'd3600;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       first;
    logic       last;
    logic       tag_ok;
    logic       empty_req;
  } item_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic [2:0]  err;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic        zneg;
    logic [6:0]  zh;
    logic [6:0]  zm;
    logic        dbad;
  } state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic        zneg;
    logic [6:0]  zh;
    logic [6:0]  zm;
  } res_t;

  localparam state_t STATE_CLEAR = '0;

  // a * 10 + d, kept to 14 bits
  function automatic logic [13:0] acc10(input logic [13:0] a, input logic [3:0] d);
    acc10 = 14'(a * 14'd10 + {10'd0, d});
  endfunction

endpackage

`default_nettype wire

@@ hdl/utsp_if.sv @@
// valid/ready channel interfaces for the time string parser
// depends on nothing
`default_nettype none

interface utsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       first;
  logic       last;
  logic       tag_ok;
  logic       empty_req;

  modport source (output valid, char_byte, first, last, tag_ok, empty_req, input ready);
  modport sink (input valid, char_byte, first, last, tag_ok, empty_req, output ready);
endinterface

interface utsp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [13:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic signed [17:0] offset_seconds;

  modport source (output valid, status, year, month, day, hour, minute, offset_seconds,
                  input ready);
  modport sink (input valid, status, year, month, day, hour, minute, offset_seconds,
                output ready);
endinterface

`default_nettype wire

@@ hdl/utsp_parse.sv @@
// per-byte parse step: position counter, field accumulators, sticky error
// depends on utsp_pkg and utc_time_string_parser_defines.svh
`default_nettype none
`include "utc_time_string_parser_defines.svh"

module utsp_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_vld,
  input  wire utsp_pkg::item_t item,
  input  wire logic           out_free,
  output logic                go,
  output logic                emit,
  output utsp_pkg::res_t      res
);

  utsp_pkg::state_t st_r, st_nxt;
  utsp_pkg::state_t base, nx;
  logic             dig;
  logic [7:0]       dsub;
  logic [3:0]       d;
  logic             bad;
  logic [13:0]      acc;
  logic [2:0]       st_fin;

  function automatic utsp_pkg::state_t zone_char(input utsp_pkg::state_t s,
                                                 input logic [7:0] b);
    utsp_pkg::state_t r;
    r = s;
    if (b == utsp_pkg::CHAR_Z) begin
      r.zneg  = 1'b0;
      r.phase = utsp_pkg::PH_DONE;
    end else if (b == utsp_pkg::CHAR_PLUS) begin
      r.zneg  = 1'b0;
      r.phase = utsp_pkg::PH_ZH1;
    end else if (b == utsp_pkg::CHAR_MINUS) begin
      r.zneg  = 1'b1;
      r.phase = utsp_pkg::PH_ZH1;
    end else begin
      r.err = utsp_pkg::ST_ZONE;
    end
    return r;
  endfunction

  always_comb begin
    dig  = (item.char_byte >= utsp_pkg::CHAR_0) && (item.char_byte <= utsp_pkg::CHAR_9);
    dsub = item.char_byte - utsp_pkg::CHAR_0;
    d    = dig ? dsub[3:0] : 4'd0;
    bad  = 1'b0;
    acc  = '0;

    // new value starts from a clean state
    if (item.first) begin
      base     = utsp_pkg::STATE_CLEAR;
      base.err = item.tag_ok ? utsp_pkg::ST_OK : utsp_pkg::ST_TAG;
    end else begin
      base = st_r;
    end
    nx = base;

    if (base.err == utsp_pkg::ST_OK) begin
      if (base.phase < utsp_pkg::PH_AFTER_HOUR) begin
        if (!dig) begin
          nx.dbad = 1'b1;
        end else if (base.phase < utsp_pkg::PH_MONTH1) begin
          nx.year = utsp_pkg::acc10(base.year, d);
        end else if (base.phase < utsp_pkg::PH_DAY1) begin
          acc      = utsp_pkg::acc10({7'd0, base.month}, d);
          nx.month = acc[6:0];
        end else if (base.phase < utsp_pkg::PH_HOUR1) begin
          acc    = utsp_pkg::acc10({7'd0, base.day}, d);
          nx.day = acc[6:0];
        end else begin
          acc     = utsp_pkg::acc10({7'd0, base.hour}, d);
          nx.hour = acc[6:0];
        end
        // field complete: check digits and range
        if (base.phase == utsp_pkg::PH_YEAR4 || base.phase == utsp_pkg::PH_MONTH2 ||
            base.phase == utsp_pkg::PH_DAY2 || base.phase == utsp_pkg::PH_HOUR2) begin
          bad = nx.dbad;
          if (base.phase == utsp_pkg::PH_YEAR4)
            bad = bad || (nx.year < utsp_pkg::YEAR_MIN);
          if (base.phase == utsp_pkg::PH_MONTH2)
            bad = bad || (nx.month == 7'd0) || (nx.month > utsp_pkg::MONTH_MAX);
          if (base.phase == utsp_pkg::PH_DAY2)
            bad = bad || (nx.day == 7'd0) || (nx.day > utsp_pkg::DAY_MAX);
          if (base.phase == utsp_pkg::PH_HOUR2)
            bad = bad || (nx.hour > utsp_pkg::HOUR_MAX);
          nx.dbad = 1'b0;
        end
        if (bad) nx.err = utsp_pkg::ST_RANGE;
        else nx.phase = base.phase + 5'd1;
      end else begin
        case (base.phase)
          utsp_pkg::PH_AFTER_HOUR: begin
            if (dig) begin
              nx.minute = {3'd0, d};
              nx.phase  = utsp_pkg::PH_MIN2;
            end else begin
              nx = zone_char(base, item.char_byte);
            end
          end
          utsp_pkg::PH_MIN2: begin
            if (!dig) begin
              nx.err = utsp_pkg::ST_ZONE;
            end else begin
              acc       = utsp_pkg::acc10({7'd0, base.minute}, d);
              nx.minute = acc[6:0];
              if (acc[6:0] > utsp_pkg::MIN_MAX) nx.err = utsp_pkg::ST_RANGE;
              else nx.phase = utsp_pkg::PH_ZONE;
            end
          end
          utsp_pkg::PH_ZONE: nx = zone_char(base, item.char_byte);
          utsp_pkg::PH_ZH1: begin
            if (!dig) nx.dbad = 1'b1;
            else nx.zh = {3'd0, d};
            nx.phase = utsp_pkg::PH_ZH2;
          end
          utsp_pkg::PH_ZH2: begin
            if (!dig || base.dbad) begin
              nx.err = utsp_pkg::ST_RANGE;
            end else begin
              acc   = utsp_pkg::acc10({7'd0, base.zh}, d);
              nx.zh = acc[6:0];
              if (acc[6:0] > utsp_pkg::HOUR_MAX) nx.err = utsp_pkg::ST_RANGE;
              else nx.phase = utsp_pkg::PH_ZM1;
            end
          end
          utsp_pkg::PH_ZM1: begin
            if (!dig) begin
              nx.err = utsp_pkg::ST_LEN;
            end else begin
              nx.zm    = {3'd0, d};
              nx.phase = utsp_pkg::PH_ZM2;
            end
          end
          utsp_pkg::PH_ZM2: begin
            if (!dig) begin
              nx.err = utsp_pkg::ST_LEN;
            end else begin
              acc   = utsp_pkg::acc10({7'd0, base.zm}, d);
              nx.zm = acc[6:0];
              if (acc[6:0] > utsp_pkg::MIN_MAX) nx.err = utsp_pkg::ST_RANGE;
              else nx.phase = utsp_pkg::PH_DONE;
            end
          end
          default: nx.err = utsp_pkg::ST_LEN;
        endcase
      end
    end

    // final status of a value
    st_fin = nx.err;
    if (nx.err == utsp_pkg::ST_OK) begin
      if (nx.phase == utsp_pkg::PH_MIN2) st_fin = utsp_pkg::ST_ZONE;
      else if (nx.phase != utsp_pkg::PH_ZM1 && nx.phase != utsp_pkg::PH_DONE)
        st_fin = utsp_pkg::ST_LEN;
    end

    res.year   = nx.year;
    res.month  = nx.month;
    res.day    = nx.day;
    res.hour   = nx.hour;
    res.minute = nx.minute;
    res.zneg   = nx.zneg;
    res.zh     = nx.zh;
    res.zm     = nx.zm;
    if (item.empty_req) begin
      res.status = item.tag_ok ? utsp_pkg::ST_EMPTY : utsp_pkg::ST_TAG;
    end else begin
      res.status = st_fin;
    end

    emit   = item.empty_req || item.last;
    go     = item_vld && (!emit || out_free);
    st_nxt = emit ? utsp_pkg::STATE_CLEAR : nx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= utsp_pkg::STATE_CLEAR;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  `UTSP_ASSERT_NXT(a_clear_after_result, clk, rst_n, go && emit,
    st_r.phase == utsp_pkg::PH_START && st_r.err == utsp_pkg::ST_OK,
    "state not cleared after a result")
  `UTSP_ASSERT_NXT(a_hold_when_idle, clk, rst_n, !go, $stable(st_r),
    "parse state changed without an item")
  `UTSP_ASSERT_IMM(a_no_sticky_empty, clk, rst_n, 1'b1,
    st_r.err != utsp_pkg::ST_EMPTY && st_r.phase <= utsp_pkg::PH_DONE,
    "illegal parse state")

endmodule

`default_nettype wire

@@ hdl/utsp_result.sv @@
// result register: zone offset in seconds, zeroed fields on error, out channel
// depends on utsp_pkg, utsp_if.sv and utc_time_string_parser_defines.svh
`default_nettype none
`include "utc_time_string_parser_defines.svh"

module utsp_result (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire utsp_pkg::res_t res,
  output logic               out_free,
  utsp_out_if.source         out_ch
);

  logic               out_v_r;
  logic [2:0]         status_r, status_nxt;
  logic [13:0]        year_r, year_nxt;
  logic [3:0]         month_r, month_nxt;
  logic [4:0]         day_r, day_nxt;
  logic [4:0]         hour_r, hour_nxt;
  logic [5:0]         minute_r, minute_nxt;
  logic [17:0]        offset_r, offset_nxt;
  logic [17:0]        mag;
  logic               ok;

  always_comb begin
    ok  = (res.status == utsp_pkg::ST_OK);
    mag = 18'(18'(res.zh) * utsp_pkg::SEC_PER_HOUR) + 18'(18'(res.zm) * utsp_pkg::SEC_PER_MIN);
    status_nxt = res.status;
    year_nxt   = ok ? res.year : '0;
    month_nxt  = ok ? res.month[3:0] : '0;
    day_nxt    = ok ? res.day[4:0] : '0;
    hour_nxt   = ok ? res.hour[4:0] : '0;
    minute_nxt = ok ? res.minute[5:0] : '0;
    offset_nxt = !ok ? '0 : (res.zneg ? 18'(18'd0 - mag) : mag);
  end

  assign out_free = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = status_r;
  assign out_ch.year           = year_r;
  assign out_ch.month          = month_r;
  assign out_ch.day            = day_r;
  assign out_ch.hour           = hour_r;
  assign out_ch.minute         = minute_r;
  assign out_ch.offset_seconds = $signed(offset_r);

  `UTSP_ASSERT_IMM(a_zero_on_error, clk, rst_n, out_v_r && status_r != utsp_pkg::ST_OK,
    year_r == 14'd0 && month_r == 4'd0 && minute_r == 6'd0 && offset_r == 18'd0,
    "value fields not zero on error")
  `UTSP_ASSERT_IMM(a_range_on_ok, clk, rst_n, out_v_r && status_r == utsp_pkg::ST_OK,
    year_r >= utsp_pkg::YEAR_MIN && month_r != 4'd0 && month_r <= 4'd12 && day_r != 5'd0,
    "ok result with field out of range")
  `UTSP_ASSERT_NXT(a_load_shows, clk, rst_n, load, out_v_r,
    "loaded result not presented")

endmodule

`default_nettype wire

@@ hdl/utc_time_string_parser.sv @@
// Time string parser, top level: input register, parse step, result register.
// Depends on utsp_pkg, utsp_if.sv, utsp_parse and utsp_result.
//
// in_ch carries one content byte per item with first/last markers, tag_ok
// (sampled with first or empty_req) and empty_req. An item with last or
// empty_req set produces exactly one item on out_ch: status, year, month,
// day, hour, minute and the signed zone offset in seconds. Other items
// produce nothing and only advance the parse state.
// An accepted item is held in the input register and parsed from there, and
// its result is captured in the result register that drives out_ch.
// Throughput: one item per cycle unless a result item waits for out_ch; the
// single parse step between the input and result registers sets that figure.
// A result waiting on out_ch does not stop items that produce no result;
// a result-producing item waits in the input register until the result
// register is free, and in_ch.ready stays low while it waits.
// Reset (synchronous, rst_n low) clears the input and result valid flags and
// the parse state; a byte without first after reset starts a new value.
`default_nettype none

module utc_time_string_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  utsp_in_if.sink    in_ch,
  utsp_out_if.source out_ch
);

  logic            in_v_r;
  utsp_pkg::item_t item_r;
  logic            go;
  logic            emit;
  logic            out_free;
  utsp_pkg::res_t  res;

  assign in_ch.ready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.char_byte <= in_ch.char_byte;
      item_r.first     <= in_ch.first;
      item_r.last      <= in_ch.last;
      item_r.tag_ok    <= in_ch.tag_ok;
      item_r.empty_req <= in_ch.empty_req;
    end
  end

  utsp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_v_r),
    .item     (item_r),
    .out_free (out_free),
    .go       (go),
    .emit     (emit),
    .res      (res)
  );

  utsp_result u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (go && emit),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
